// ----- rtl/cesa_pkg.sv -----
// Shared types, constants and constant functions of the cell event sweep angle block.
package cesa_pkg;

    // Coordinate and datapath widths fixed by the cell and event formats.
    localparam int COORD_W = 12;
    localparam int HALF_W  = 14;
    localparam int DIFF_W  = 15;
    localparam int MAG_W   = 13;

    // CORDIC datapath: x and y carry the magnitudes scaled by 2^40, z is Q.40 radians.
    localparam int ZFRAC = 40;
    localparam int XY_W  = 56;
    localparam int Z_W   = 43;

    // Pi and pi/4 in Q.40, rounded to nearest.
    localparam logic [63:0] PI_Q40         = 64'd3454217652358;
    localparam logic [63:0] QUARTER_PI_Q40 = 64'd863554413089;

    // Configuration register indexes.
    localparam logic CFG_VP_ROW = 1'b0;
    localparam logic CFG_VP_COL = 1'b1;

    // Event kinds carried on the input tuser; the fourth code behaves as an exit.
    typedef enum logic [1:0] {
        EV_ENTER,
        EV_CENTER,
        EV_EXIT,
        EV_EXIT_ALIAS
    } event_kind_t;

    // How the final angle is formed from the first-quadrant angle.
    typedef enum logic [2:0] {
        SEL_ZERO,
        SEL_HALF_PI,
        SEL_PI,
        SEL_THREE_HALF_PI,
        SEL_Q1,
        SEL_Q2,
        SEL_Q3,
        SEL_Q4
    } ang_sel_t;

    // Per-item information that rides along the rotation stages.
    typedef struct packed {
        logic signed [HALF_W-1:0] row_half;
        logic signed [HALF_W-1:0] col_half;
        logic                     at_vp;
        ang_sel_t                 sel;
    } side_t;

    // State of one vectoring rotation step.
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        side_t                  side;
    } rot_t;

    function automatic logic [63:0] pow2(input int e);
        logic [63:0] p;
        if (e < 0)
        begin
            p = '0;
        end
        else
        begin
            p = 64'd1 << e;
        end
        return p;
    endfunction

    // atan(2^-i) in Q.40, from the Q.60 power series rounded to nearest.
    function automatic logic [63:0] atan_q40(input int i);
        logic [63:0] s;
        if (i == 0)
        begin
            s = QUARTER_PI_Q40;
        end
        else
        begin
            s = pow2(60 - i);
            s = s - pow2(60 - 3 * i) / 64'd3;
            s = s + pow2(60 - 5 * i) / 64'd5;
            s = s - pow2(60 - 7 * i) / 64'd7;
            s = s + pow2(60 - 9 * i) / 64'd9;
            s = s - pow2(60 - 11 * i) / 64'd11;
            s = s + pow2(60 - 13 * i) / 64'd13;
            s = s - pow2(60 - 15 * i) / 64'd15;
            s = s + pow2(60 - 17 * i) / 64'd17;
            s = s - pow2(60 - 19 * i) / 64'd19;
            s = s + pow2(60 - 21 * i) / 64'd21;
            s = s - pow2(60 - 23 * i) / 64'd23;
            s = s + pow2(60 - 25 * i) / 64'd25;
            s = s - pow2(60 - 27 * i) / 64'd27;
            s = s + pow2(60 - 29 * i) / 64'd29;
            s = s - pow2(60 - 31 * i) / 64'd31;
            s = s + pow2(60 - 33 * i) / 64'd33;
            s = s - pow2(60 - 35 * i) / 64'd35;
            s = s + pow2(60 - 37 * i) / 64'd37;
            s = s - pow2(60 - 39 * i) / 64'd39;
            s = s + pow2(60 - 41 * i) / 64'd41;
            s = s - pow2(60 - 43 * i) / 64'd43;
            s = s + pow2(60 - 45 * i) / 64'd45;
            s = s - pow2(60 - 47 * i) / 64'd47;
            s = s + pow2(60 - 49 * i) / 64'd49;
            s = s - pow2(60 - 51 * i) / 64'd51;
            s = s + pow2(60 - 53 * i) / 64'd53;
            s = s - pow2(60 - 55 * i) / 64'd55;
            s = s + pow2(60 - 57 * i) / 64'd57;
            s = s - pow2(60 - 59 * i) / 64'd59;
            s = (s + (64'd1 << 19)) >> 20;
        end
        return s;
    endfunction

endpackage

// ----- rtl/cell_event_sweep_angle.sv -----
// Top level of the cell event sweep angle block: event point and CORDIC sweep angle.
//
// Usage: each item on the s_ channel is one raster cell and its event kind. The block
// moves enter and exit points half a cell toward the corner picked by the quadrant rules
// around the viewpoint and returns the point in half-cell units, the sweep angle seen
// from the viewpoint (radians, ANGLE_FRAC_BITS fraction bits, counter-clockwise from
// east with rows growing southward) and a flag that marks the viewpoint cell itself.
// The viewpoint is set through cfg_we / cfg_index / cfg_data; the user must do this only
// while no item is in flight, which the block does not enforce. Throughput: one item per
// cycle while m_tready is high. The pipeline has ANGLE_FRAC_BITS + 8 register stages:
// the ANGLE_FRAC_BITS + 4 unrolled CORDIC stages plus two front stages (event point,
// magnitudes) and two back stages (rounding, quadrant mapping, the last being the
// output register).
// Every stage carries a valid bit and loads whenever it is empty or its successor moves,
// so bubbles are squeezed out and input is still taken while a result waits.
// When the receiver holds m_tready low the output register keeps its item and the
// stages behind it fill up; nothing is dropped or repeated.
// Reset clears all valid bits and sets the viewpoint to row 0, column 0.
module cell_event_sweep_angle
    import cesa_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 16
)
(
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           s_tvalid,
    output logic                                           s_tready,
    input  logic [23:0]                                    s_tdata,   // cell_row, cell_col
    input  logic [1:0]                                     s_tuser,   // req_type
    output logic                                           m_tvalid,
    input  logic                                           m_tready,
    // event_row_half, event_col_half, sweep_angle, zero fill
    output logic [((2*HALF_W+ANGLE_FRAC_BITS+3+7)/8)*8-1:0] m_tdata,
    output logic                                           m_tuser,   // is_viewpoint
    input  logic                                           cfg_we,
    input  logic                                           cfg_index,
    input  logic [COORD_W-1:0]                             cfg_data
);

    localparam int ANG_W      = ANGLE_FRAC_BITS + 3;
    localparam int ITERS      = ANGLE_FRAC_BITS + 4;
    localparam int OUT_DATA_W = ((2 * HALF_W + ANG_W + 7) / 8) * 8;
    localparam int NST        = ITERS + 4;
    localparam int ST_R1      = ITERS + 2;
    localparam int ST_R2      = ITERS + 3;
    localparam int ZSHIFT     = ZFRAC - ANGLE_FRAC_BITS;
    localparam logic [63:0] ROUND_Q40 = 64'd1 << (ZSHIFT - 1);

    // Angle constants rounded to nearest at the output precision.
    localparam logic [ANG_W-1:0] PI_ANG =
        ANG_W'((PI_Q40 + ROUND_Q40) >> ZSHIFT);
    localparam logic [ANG_W-1:0] HALF_PI_ANG =
        ANG_W'(((PI_Q40 >> 1) + ROUND_Q40) >> ZSHIFT);
    localparam logic [ANG_W-1:0] THREE_HALF_PI_ANG =
        ANG_W'((64'd3 * (PI_Q40 >> 1) + ROUND_Q40) >> ZSHIFT);
    localparam logic [ANG_W-1:0] TWO_PI_ANG =
        ANG_W'((64'd2 * PI_Q40 + ROUND_Q40) >> ZSHIFT);

    // ------------------------------------------------------------------
    // Viewpoint registers.
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] vp_row_reg;
    logic [COORD_W-1:0] vp_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vp_row_reg <= '0;
            vp_col_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_VP_ROW: vp_row_reg <= cfg_data;
                CFG_VP_COL: vp_col_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. A stage loads when it is empty or its content moves on.
    // ------------------------------------------------------------------
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] load;

    always_comb
    begin
        load[NST-1] = !vld_reg[NST-1] || m_tready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            load[k] = !vld_reg[k] || load[k+1];
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (load[0])
        begin
            vld_next[0] = s_tvalid;
        end
        for (int k = 1; k < NST; k++)
        begin
            if (load[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = load[0];
    assign m_tvalid = vld_reg[NST-1];

    // ------------------------------------------------------------------
    // Stage A: quadrant rules, event point and offsets from the viewpoint.
    // ------------------------------------------------------------------
    logic [COORD_W-1:0]       in_row;
    logic [COORD_W-1:0]       in_col;
    logic                     row_lt;
    logic                     row_eq;
    logic                     col_lt;
    logic                     col_eq;
    logic                     enter;
    logic                     at_vp;
    logic signed [1:0]        dr;
    logic signed [1:0]        dc;
    logic signed [HALF_W-1:0] row_half_a;
    logic signed [HALF_W-1:0] col_half_a;
    logic signed [DIFF_W-1:0] dx_a;
    logic signed [DIFF_W-1:0] dy_a;

    logic signed [HALF_W-1:0] a_row_half_reg;
    logic signed [HALF_W-1:0] a_col_half_reg;
    logic                     a_at_vp_reg;
    logic signed [DIFF_W-1:0] a_dx_reg;
    logic signed [DIFF_W-1:0] a_dy_reg;

    assign in_row = s_tdata[COORD_W-1:0];
    assign in_col = s_tdata[2*COORD_W-1:COORD_W];
    assign row_lt = in_row < vp_row_reg;
    assign row_eq = in_row == vp_row_reg;
    assign col_lt = in_col < vp_col_reg;
    assign col_eq = in_col == vp_col_reg;
    assign enter  = s_tuser == EV_ENTER;
    assign at_vp  = row_eq && col_eq;

    // Enter and exit events move half a cell toward the corner that the sector of the
    // cell around the viewpoint selects; kind 3 behaves as an exit event.
    always_comb
    begin
        dr = 2'sd0;
        dc = 2'sd0;
        if (!at_vp && s_tuser != EV_CENTER)
        begin
            if (row_lt && col_lt)
            begin
                dr = enter ? -2'sd1 : 2'sd1;
                dc = enter ? 2'sd1 : -2'sd1;
            end
            else if (row_lt && col_eq)
            begin
                dr = 2'sd1;
                dc = enter ? 2'sd1 : -2'sd1;
            end
            else if (row_lt)
            begin
                dr = enter ? 2'sd1 : -2'sd1;
                dc = enter ? 2'sd1 : -2'sd1;
            end
            else if (row_eq && !col_lt)
            begin
                dr = enter ? 2'sd1 : -2'sd1;
                dc = -2'sd1;
            end
            else if (!row_eq && !col_lt && !col_eq)
            begin
                dr = enter ? 2'sd1 : -2'sd1;
                dc = enter ? -2'sd1 : 2'sd1;
            end
            else if (!row_eq && col_eq)
            begin
                dr = -2'sd1;
                dc = enter ? -2'sd1 : 2'sd1;
            end
            else if (!row_eq)
            begin
                dr = enter ? -2'sd1 : 2'sd1;
                dc = enter ? -2'sd1 : 2'sd1;
            end
            else
            begin
                dr = enter ? -2'sd1 : 2'sd1;
                dc = 2'sd1;
            end
        end
    end

    assign row_half_a = {1'b0, in_row, 1'b0} + {{(HALF_W-2){dr[1]}}, dr};
    assign col_half_a = {1'b0, in_col, 1'b0} + {{(HALF_W-2){dc[1]}}, dc};
    assign dx_a = {col_half_a[HALF_W-1], col_half_a} - {2'b00, vp_col_reg, 1'b0};
    assign dy_a = {2'b00, vp_row_reg, 1'b0} - {row_half_a[HALF_W-1], row_half_a};

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            a_row_half_reg <= row_half_a;
            a_col_half_reg <= col_half_a;
            a_at_vp_reg    <= at_vp;
            a_dx_reg       <= dx_a;
            a_dy_reg       <= dy_a;
        end
    end

    // ------------------------------------------------------------------
    // Stage B: magnitudes, quadrant selection and CORDIC start vector.
    // ------------------------------------------------------------------
    logic [MAG_W-1:0] mag_x;
    logic [MAG_W-1:0] mag_y;
    logic [DIFF_W-1:0] neg_dx;
    logic [DIFF_W-1:0] neg_dy;
    ang_sel_t          sel_b;
    rot_t              b_next;
    rot_t              b_reg;

    assign neg_dx = -a_dx_reg;
    assign neg_dy = -a_dy_reg;
    assign mag_x  = a_dx_reg[DIFF_W-1] ? neg_dx[MAG_W-1:0] : a_dx_reg[MAG_W-1:0];
    assign mag_y  = a_dy_reg[DIFF_W-1] ? neg_dy[MAG_W-1:0] : a_dy_reg[MAG_W-1:0];

    always_comb
    begin
        if (a_at_vp_reg || (a_dx_reg == '0 && a_dy_reg == '0))
        begin
            sel_b = SEL_ZERO;
        end
        else if (a_dy_reg == '0)
        begin
            sel_b = a_dx_reg[DIFF_W-1] ? SEL_PI : SEL_ZERO;
        end
        else if (a_dx_reg == '0)
        begin
            sel_b = a_dy_reg[DIFF_W-1] ? SEL_THREE_HALF_PI : SEL_HALF_PI;
        end
        else if (!a_dx_reg[DIFF_W-1] && !a_dy_reg[DIFF_W-1])
        begin
            sel_b = SEL_Q1;
        end
        else if (!a_dy_reg[DIFF_W-1])
        begin
            sel_b = SEL_Q2;
        end
        else if (a_dx_reg[DIFF_W-1])
        begin
            sel_b = SEL_Q3;
        end
        else
        begin
            sel_b = SEL_Q4;
        end
    end

    always_comb
    begin
        b_next.x = {{(XY_W-MAG_W-ZFRAC){1'b0}}, mag_x, {ZFRAC{1'b0}}};
        b_next.y = {{(XY_W-MAG_W-ZFRAC){1'b0}}, mag_y, {ZFRAC{1'b0}}};
        b_next.z = '0;
        b_next.side.row_half = a_row_half_reg;
        b_next.side.col_half = a_col_half_reg;
        b_next.side.at_vp    = a_at_vp_reg;
        b_next.side.sel      = sel_b;
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            b_reg <= b_next;
        end
    end

    // ------------------------------------------------------------------
    // Unrolled CORDIC: one micro-rotation per stage.
    // ------------------------------------------------------------------
    rot_t rot_chain [ITERS+1];

    assign rot_chain[0] = b_reg;

    for (genvar g = 0; g < ITERS; g++)
    begin : g_cordic
        cesa_cordic_stage #(
            .ITER(g)
        ) u_stage (
            .clk  (clk),
            .load (load[g+2]),
            .d_in (rot_chain[g]),
            .d_out(rot_chain[g+1])
        );
    end

    // ------------------------------------------------------------------
    // Stage R1: clamp the accumulated angle at zero, round to the output
    // precision and clamp at pi/2.
    // ------------------------------------------------------------------
    rot_t              rot_last;
    logic [Z_W-2:0]    z_pos;
    logic [Z_W-2:0]    z_sum;
    logic [Z_W-2:0]    z_rnd;
    logic [ANG_W-1:0]  a_r1;
    side_t             r1_side_reg;
    logic [ANG_W-1:0]  r1_ang_reg;

    assign rot_last = rot_chain[ITERS];
    assign z_pos    = rot_last.z[Z_W-1] ? '0 : rot_last.z[Z_W-2:0];
    assign z_sum    = z_pos + (Z_W-1)'(ROUND_Q40);
    assign z_rnd    = z_sum >> ZSHIFT;
    assign a_r1     = (z_rnd > (Z_W-1)'(HALF_PI_ANG)) ? HALF_PI_ANG : z_rnd[ANG_W-1:0];

    always_ff @(posedge clk)
    begin
        if (load[ST_R1])
        begin
            r1_side_reg <= rot_last.side;
            r1_ang_reg  <= a_r1;
        end
    end

    // ------------------------------------------------------------------
    // Stage R2: map to the full circle; this is the output register.
    // ------------------------------------------------------------------
    logic [ANG_W-1:0]         ang_map;
    logic [ANG_W-1:0]         ang_r2;
    logic signed [HALF_W-1:0] out_row_half_reg;
    logic signed [HALF_W-1:0] out_col_half_reg;
    logic [ANG_W-1:0]         out_ang_reg;
    logic                     out_vp_reg;

    always_comb
    begin
        case (r1_side_reg.sel)
            SEL_ZERO:          ang_map = '0;
            SEL_HALF_PI:       ang_map = HALF_PI_ANG;
            SEL_PI:            ang_map = PI_ANG;
            SEL_THREE_HALF_PI: ang_map = THREE_HALF_PI_ANG;
            SEL_Q1:            ang_map = r1_ang_reg;
            SEL_Q2:            ang_map = PI_ANG - r1_ang_reg;
            SEL_Q3:            ang_map = PI_ANG + r1_ang_reg;
            SEL_Q4:            ang_map = TWO_PI_ANG - r1_ang_reg;
            default:           ang_map = '0;
        endcase
    end

    // A full turn folds back to zero.
    assign ang_r2 = (ang_map >= TWO_PI_ANG) ? '0 : ang_map;

    always_ff @(posedge clk)
    begin
        if (load[ST_R2])
        begin
            out_row_half_reg <= r1_side_reg.row_half;
            out_col_half_reg <= r1_side_reg.col_half;
            out_ang_reg      <= ang_r2;
            out_vp_reg       <= r1_side_reg.at_vp;
        end
    end

    assign m_tdata = OUT_DATA_W'({out_ang_reg, out_col_half_reg, out_row_half_reg});
    assign m_tuser = out_vp_reg;

endmodule

// ----- rtl/cesa_cordic_stage.sv -----
// One registered vectoring micro-rotation of the arctangent pipeline.
module cesa_cordic_stage
    import cesa_pkg::*;
#(
    parameter int ITER = 0
)
(
    input  logic clk,
    input  logic load,
    input  rot_t d_in,
    output rot_t d_out
);

    localparam logic signed [Z_W-1:0] STEP = Z_W'(atan_q40(ITER));

    rot_t q_reg;
    rot_t q_next;

    logic signed [XY_W-1:0] x_in;
    logic signed [XY_W-1:0] y_in;
    logic signed [XY_W-1:0] x_sh;
    logic signed [XY_W-1:0] y_sh;
    logic signed [Z_W-1:0]  z_in;

    assign x_in = d_in.x;
    assign y_in = d_in.y;
    assign z_in = d_in.z;
    assign x_sh = x_in >>> ITER;
    assign y_sh = y_in >>> ITER;

    // Rotate toward the x axis; the arithmetic shifts round toward minus infinity.
    always_comb
    begin
        q_next = d_in;
        if (!y_in[XY_W-1])
        begin
            q_next.x = x_in + y_sh;
            q_next.y = y_in - x_sh;
            q_next.z = z_in + STEP;
        end
        else
        begin
            q_next.x = x_in - y_sh;
            q_next.y = y_in + x_sh;
            q_next.z = z_in - STEP;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            q_reg <= q_next;
        end
    end

    assign d_out = q_reg;

endmodule
